### src/sorted_array_table_top_defines.svh
// assertion macros shared by the sorted array table
`ifndef SORTED_ARRAY_TABLE_TOP_DEFINES_SVH
`define SORTED_ARRAY_TABLE_TOP_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define SAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds in the cycle after
`define SAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sat_pkg.sv
// types and constants of the sorted array table
`default_nettype none

package sat_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned OUT_W   = 6;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    action_e              action;
    logic [VALUE_W-1:0]   value;
    logic [POS_W-1:0]     position;
    logic                 ins_en;
    logic                 del_en;
  } ctrl_t;

endpackage

`default_nettype wire

### src/sat_cell.sv
// one table position: holds an entry and trades it with its neighbours
`default_nettype none

module sat_cell import sat_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CNT_W = 6
) (
  input  wire logic               clk_i,
  input  wire ctrl_t              ctrl_i,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic               left_gt_i,
  input  wire logic               left_eq_i,
  input  wire logic [VALUE_W-1:0] left_entry_i,
  input  wire logic [VALUE_W-1:0] right_entry_i,
  output logic [VALUE_W-1:0]      entry_o,
  output logic                    gt_o,
  output logic                    eq_o,
  output logic                    mark_o
);

  logic [VALUE_W-1:0] entry_q;
  logic               valid;
  logic               tail;
  logic               hit;
  logic               land;
  logic               first_eq;

  // occupancy of this position
  assign valid = INDEX < int'(count_i);
  assign tail  = INDEX == int'(count_i);
  assign hit   = int'(ctrl_i.position) == INDEX;

  // local compares against the broadcast value
  assign gt_o = valid && ($signed(entry_q) > $signed(ctrl_i.value));
  assign eq_o = valid && (entry_q == ctrl_i.value);

  // insert lands where the larger run starts, or at the tail
  assign land     = !left_gt_i && (gt_o || tail);
  // start of the run of equal entries
  assign first_eq = eq_o && !left_eq_i;

  always_comb begin
    case (ctrl_i.action)
      ACT_INSERT: mark_o = land;
      ACT_SEARCH: mark_o = first_eq;
      ACT_DELETE: mark_o = hit;
      ACT_READ:   mark_o = hit;
      default:    mark_o = 1'b0;
    endcase
  end

  // shift up on insert, shift down on delete
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en) begin
      if (left_gt_i) begin
        entry_q <= left_entry_i;
      end else if (land) begin
        entry_q <= ctrl_i.value;
      end
    end else if (ctrl_i.del_en && (int'(ctrl_i.position) <= INDEX)) begin
      entry_q <= right_entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

### src/sorted_array_table_top.sv
// sorted array table: controller and row of compare-and-shift cells
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-----------------------------------
//  in      | in        | in_valid_i / in_ready_o | action, value, position
//  out     | out       | out_valid_o/out_ready_i | status, found_position, read_value,
//          |           |                         | entry_count
//
// a request is first registered, then every cell compares
// and shifts at once; the result then sits in the output register
// the next request is taken in the cycle the previous result is taken
// reset clears the entry count and the controller; entries are not cleared
// a stalled output holds the result and keeps the next request waiting
`default_nettype none

module sorted_array_table_top import sat_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                action_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire logic [POS_W-1:0]          position_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [1:0]                     status_o,
  output logic [OUT_W-1:0]               found_position_o,
  output logic signed [VALUE_W-1:0]      read_value_o,
  output logic [OUT_W-1:0]               entry_count_o
);

`include "sorted_array_table_top_defines.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  action_e             act_q;
  logic [VALUE_W-1:0]  val_q;
  logic [POS_W-1:0]    pos_q;
  logic                in_acc;
  logic                exec;

  status_e             status_q, status_d;
  logic [OUT_W-1:0]    where_q, where_d;
  logic [VALUE_W-1:0]  rd_q, rd_d;
  logic [OUT_W-1:0]    cnt_out_q;

  ctrl_t               ctrl;
  logic                full;
  logic                pos_ok;

  logic [VALUE_W-1:0]  entry_w [CAPACITY];
  logic [CAPACITY-1:0] gt_w;
  logic [CAPACITY-1:0] eq_w;
  logic [CAPACITY-1:0] mark_w;
  logic [OUT_W-1:0]    where_or;
  logic [VALUE_W-1:0]  data_or;

  // handshake
  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_DONE) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = state_q == S_DONE;
  assign exec        = state_q == S_EXEC;

  // controller
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_DONE;
      S_DONE: begin
        if (out_ready_i) state_d = in_valid_i ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // request register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_e'(action_i);
      val_q <= value_i;
      pos_q <= position_i;
    end
  end

  assign full   = count_q == CNT_W'(CAPACITY);
  assign pos_ok = PW'(pos_q) < PW'(count_q);

  // broadcast to the cells
  always_comb begin
    ctrl.action   = act_q;
    ctrl.value    = val_q;
    ctrl.position = pos_q;
    ctrl.ins_en   = exec && (act_q == ACT_INSERT) && !full;
    ctrl.del_en   = exec && (act_q == ACT_DELETE) && pos_ok;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               l_gt;
    logic               l_eq;
    logic [VALUE_W-1:0] l_entry;
    logic [VALUE_W-1:0] r_entry;

    if (i == 0) begin : g_first
      assign l_gt    = 1'b0;
      assign l_eq    = 1'b0;
      assign l_entry = '0;
    end else begin : g_mid
      assign l_gt    = gt_w[i-1];
      assign l_eq    = eq_w[i-1];
      assign l_entry = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_entry = '0;
    end else begin : g_inner
      assign r_entry = entry_w[i+1];
    end

    sat_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_gt_i     (l_gt),
      .left_eq_i     (l_eq),
      .left_entry_i  (l_entry),
      .right_entry_i (r_entry),
      .entry_o       (entry_w[i]),
      .gt_o          (gt_w[i]),
      .eq_o          (eq_w[i]),
      .mark_o        (mark_w[i])
    );
  end

  // gather the one marked cell's index and entry
  always_comb begin
    where_or = '0;
    data_or  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (mark_w[i]) begin
        where_or = where_or | OUT_W'(i);
        data_or  = data_or | entry_w[i];
      end
    end
  end

  // result and new count
  always_comb begin
    status_d = ST_OK;
    where_d  = '0;
    rd_d     = '0;
    count_d  = count_q;
    if (exec) begin
      case (act_q)
        ACT_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            where_d = where_or;
            count_d = count_q + CNT_W'(1);
          end
        end
        ACT_DELETE: begin
          if (!pos_ok) begin
            status_d = ST_BAD_POS;
          end else begin
            rd_d    = data_or;
            count_d = count_q - CNT_W'(1);
          end
        end
        ACT_SEARCH: begin
          if (|eq_w) begin
            where_d = where_or;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        ACT_READ: begin
          if (!pos_ok) begin
            status_d = ST_BAD_POS;
          end else begin
            rd_d = data_or;
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q  <= status_d;
      where_q   <= where_d;
      rd_q      <= rd_d;
      cnt_out_q <= OUT_W'(count_d);
    end
  end

  assign status_o         = status_q;
  assign found_position_o = where_q;
  assign read_value_o     = rd_q;
  assign entry_count_o    = cnt_out_q;

  // checks
  `SAT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count beyond capacity")
  `SAT_ASSERT_IMP(a_full_count, out_valid_o && (status_o == ST_FULL),
                  entry_count_o == OUT_W'(CAPACITY), "full refused below capacity")
  `SAT_ASSERT_NXT(a_accept_exec, in_valid_i && in_ready_o,
                  state_q == S_EXEC, "accepted word not executed")
  `SAT_ASSERT_NXT(a_count_step, exec && (act_q == ACT_SEARCH || act_q == ACT_READ),
                  $stable(count_q), "count moved on a lookup")

endmodule

`default_nettype wire

### tb/sorted_array_table_top_tb.sv
// self-checking testbench of the sorted array table: directed rows then random requests
`default_nettype none

module sorted_array_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam int CAPACITY  = 32;
  localparam int HALF_CLK  = 5;
  localparam int RAND_REQS = 650;

  // one answer word as the block reports it
  typedef struct packed {
    status_e           status;
    logic [OUT_W-1:0]  fpos;
    logic [31:0]       rdval;
    logic [OUT_W-1:0]  cnt;
  } answer_t;

  // one row of the opening script
  typedef struct packed {
    action_e     act;
    logic [31:0] val;
    logic [4:0]  pos;
    logic        typed;
    answer_t     ans;
  } step_t;

  typedef enum logic [1:0] {
    PH_GROW,
    PH_DRAIN,
    PH_MIX
  } phase_e;

  localparam step_t OPENING_ROWS [25] = '{
    // empty table: bad positions and a miss
    '{ACT_READ,   32'h0000_0000, 5'd0,  1'b1, '{ST_BAD_POS,   6'd0, 32'h0000_0000, 6'd0}},
    '{ACT_DELETE, 32'hDEAD_BEEF, 5'd31, 1'b1, '{ST_BAD_POS,   6'd0, 32'h0000_0000, 6'd0}},
    '{ACT_SEARCH, 32'h0000_0000, 5'd0,  1'b1, '{ST_NOT_FOUND, 6'd0, 32'h0000_0000, 6'd0}},
    // extremes and equal values
    '{ACT_INSERT, 32'h7FFF_FFFF, 5'd0,  1'b1, '{ST_OK,        6'd0, 32'h0000_0000, 6'd1}},
    '{ACT_INSERT, 32'h8000_0000, 5'd31, 1'b1, '{ST_OK,        6'd0, 32'h0000_0000, 6'd2}},
    '{ACT_INSERT, 32'h0000_0000, 5'd0,  1'b1, '{ST_OK,        6'd1, 32'h0000_0000, 6'd3}},
    '{ACT_INSERT, 32'h0000_0000, 5'd0,  1'b1, '{ST_OK,        6'd2, 32'h0000_0000, 6'd4}},
    '{ACT_INSERT, 32'hFFFF_FFFF, 5'd0,  1'b1, '{ST_OK,        6'd1, 32'h0000_0000, 6'd5}},
    // searches: lowest of equals, both ends, a miss
    '{ACT_SEARCH, 32'h0000_0000, 5'd0,  1'b1, '{ST_OK,        6'd2, 32'h0000_0000, 6'd5}},
    '{ACT_SEARCH, 32'h7FFF_FFFF, 5'd0,  1'b1, '{ST_OK,        6'd4, 32'h0000_0000, 6'd5}},
    '{ACT_SEARCH, 32'h8000_0000, 5'd0,  1'b1, '{ST_OK,        6'd0, 32'h0000_0000, 6'd5}},
    '{ACT_SEARCH, 32'h0000_0005, 5'd0,  1'b1, '{ST_NOT_FOUND, 6'd0, 32'h0000_0000, 6'd5}},
    // reads inside and beyond the count
    '{ACT_READ,   32'h1234_5678, 5'd0,  1'b1, '{ST_OK,        6'd0, 32'h8000_0000, 6'd5}},
    '{ACT_READ,   32'h0000_0000, 5'd4,  1'b1, '{ST_OK,        6'd0, 32'h7FFF_FFFF, 6'd5}},
    '{ACT_READ,   32'h0000_0000, 5'd5,  1'b1, '{ST_BAD_POS,   6'd0, 32'h0000_0000, 6'd5}},
    '{ACT_READ,   32'hFFFF_FFFF, 5'd31, 1'b1, '{ST_BAD_POS,   6'd0, 32'h0000_0000, 6'd5}},
    // deletes: beyond the count, middle, top, bottom
    '{ACT_DELETE, 32'h0000_0000, 5'd5,  1'b1, '{ST_BAD_POS,   6'd0, 32'h0000_0000, 6'd5}},
    '{ACT_DELETE, 32'h0000_0000, 5'd1,  1'b1, '{ST_OK,        6'd0, 32'hFFFF_FFFF, 6'd4}},
    '{ACT_SEARCH, 32'h0000_0000, 5'd0,  1'b1, '{ST_OK,        6'd1, 32'h0000_0000, 6'd4}},
    '{ACT_DELETE, 32'h0000_0000, 5'd3,  1'b1, '{ST_OK,        6'd0, 32'h7FFF_FFFF, 6'd3}},
    '{ACT_DELETE, 32'h0000_0000, 5'd0,  1'b1, '{ST_OK,        6'd0, 32'h8000_0000, 6'd2}},
    // alternating bit patterns
    '{ACT_INSERT, 32'h5555_AAAA, 5'd0,  1'b1, '{ST_OK,        6'd2, 32'h0000_0000, 6'd3}},
    '{ACT_SEARCH, 32'hAAAA_5555, 5'd0,  1'b1, '{ST_NOT_FOUND, 6'd0, 32'h0000_0000, 6'd3}},
    '{ACT_INSERT, 32'hAAAA_5555, 5'd0,  1'b1, '{ST_OK,        6'd0, 32'h0000_0000, 6'd4}},
    '{ACT_READ,   32'h0000_0000, 5'd3,  1'b0, '0}
  };

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                action_i     = ACT_READ;
  logic signed [VALUE_W-1:0] value_i      = '0;
  logic [POS_W-1:0]          position_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic [1:0]                status_o;
  logic [OUT_W-1:0]          found_position_o;
  logic signed [VALUE_W-1:0] read_value_o;
  logic [OUT_W-1:0]          entry_count_o;

  // shadow of the table contents and count
  logic signed [31:0] shadow_vals [CAPACITY];
  int                 shadow_count = 0;

  answer_t     due_answers [$];
  int          mismatches = 0;
  int          burst_left = 0;
  int unsigned stall_tick = 0;
  int          stall_mode = 0;

  sorted_array_table_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .read_value_o    (read_value_o),
    .entry_count_o   (entry_count_o)
  );

  // clock
  always #HALF_CLK clk_i = ~clk_i;

  // apply one request to the shadow table and work out its answer
  function automatic answer_t table_request(action_e act, logic signed [31:0] v,
                                            logic [4:0] p);
    answer_t a;
    int      i;
    a = '0;
    a.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          a.status = ST_FULL;
        end else begin
          // larger entries move up one place, equal ones stay below
          i = shadow_count;
          while (i > 0 && shadow_vals[i-1] > v) begin
            shadow_vals[i] = shadow_vals[i-1];
            i--;
          end
          shadow_vals[i] = v;
          a.fpos = OUT_W'(i);
          shadow_count++;
        end
      end
      ACT_DELETE: begin
        if (int'(p) >= shadow_count) begin
          a.status = ST_BAD_POS;
        end else begin
          a.rdval = shadow_vals[p];
          for (i = int'(p); i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_count--;
        end
      end
      ACT_SEARCH: begin
        a.status = ST_NOT_FOUND;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_vals[i] == v) begin
            a.status = ST_OK;
            a.fpos   = OUT_W'(i);
            break;
          end
        end
      end
      default: begin
        if (int'(p) >= shadow_count) a.status = ST_BAD_POS;
        else a.rdval = shadow_vals[p];
      end
    endcase
    a.cnt = OUT_W'(shadow_count);
    return a;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // hold one request word until it is taken, then record its answer
  task automatic send_word(action_e act, logic [31:0] v, logic [4:0] p, logic typed,
                           answer_t typed_ans);
    answer_t a;
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= v;
    position_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    a = table_request(act, v, p);
    due_answers.push_back(typed ? typed_ans : a);
  endtask

  // sender bursts with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // receiver stall pattern, switching at random among four modes
  always @(posedge clk_i) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= (stall_tick % 4 == 3);
      default: out_ready_i <= (stall_tick % 8 != 0);
    endcase
  end

  // answer checker
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_answers.size() == 0) begin
        report_mismatch("answer word with nothing outstanding");
      end else begin
        want = due_answers.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (found_position_o !== want.fpos)
          report_mismatch($sformatf("found_position got %0d want %0d",
                                    found_position_o, want.fpos));
        if (read_value_o !== want.rdval)
          report_mismatch($sformatf("read_value got %h want %h", read_value_o, want.rdval));
        if (entry_count_o !== want.cnt)
          report_mismatch($sformatf("entry_count got %0d want %0d", entry_count_o, want.cnt));
      end
    end
  end

  // stimulus
  initial begin
    phase_e      phase;
    int          r;
    int          full_seen;
    int          empty_seen;
    int          mix_left;
    action_e     act;
    logic [31:0] v;
    logic [4:0]  p;

    phase      = PH_MIX;
    full_seen  = 0;
    empty_seen = 0;
    mix_left   = 40;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening script
    foreach (OPENING_ROWS[k]) begin
      send_word(OPENING_ROWS[k].act, OPENING_ROWS[k].val, OPENING_ROWS[k].pos,
                OPENING_ROWS[k].typed, OPENING_ROWS[k].ans);
      pace();
    end

    // random part: fill to full, drain to empty, mixed stretches in between
    for (int n = 0; n < RAND_REQS; n++) begin
      r = $urandom_range(0, 99);
      case (phase)
        PH_GROW: begin
          act = (r < 70) ? ACT_INSERT : (r < 80) ? ACT_SEARCH :
                (r < 90) ? ACT_READ : ACT_DELETE;
          if (shadow_count == CAPACITY && act == ACT_INSERT) full_seen++;
          if (full_seen >= 3) begin
            phase     = PH_DRAIN;
            full_seen = 0;
          end
        end
        PH_DRAIN: begin
          act = (r < 65) ? ACT_DELETE : (r < 78) ? ACT_READ :
                (r < 90) ? ACT_SEARCH : ACT_INSERT;
          if (shadow_count == 0 && (act == ACT_DELETE || act == ACT_READ)) empty_seen++;
          if (empty_seen >= 2) begin
            phase      = PH_MIX;
            empty_seen = 0;
            mix_left   = $urandom_range(30, 80);
          end
        end
        default: begin
          act = (r < 30) ? ACT_INSERT : (r < 55) ? ACT_DELETE :
                (r < 78) ? ACT_SEARCH : ACT_READ;
          mix_left--;
          if (mix_left <= 0) phase = PH_GROW;
        end
      endcase

      // values: small pool for duplicates, present entries, extremes, anything
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = 32'($urandom_range(0, 15)) - 32'd8;
        4, 5:       v = (shadow_count > 0) ?
                        shadow_vals[$urandom_range(0, shadow_count - 1)] : $urandom;
        6: begin
          case ($urandom_range(0, 3))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
          endcase
        end
        default:    v = $urandom;
      endcase

      // positions mostly inside the count
      if (shadow_count > 0 && $urandom_range(0, 4) != 0)
        p = 5'($urandom_range(0, shadow_count - 1));
      else
        p = 5'($urandom_range(0, 31));

      send_word(act, v, p, 1'b0, '0);
      pace();
    end
    in_valid_i <= 1'b0;

    // drain outstanding answers, then a short quiet spell
    while (due_answers.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[sorted_array_table_top] OK");
    end else begin
      $display("[sorted_array_table_top] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[sorted_array_table_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
